>>> hdl/xkld_pkg.sv
// ----------------------------------------------------------------------------
// xkld_pkg
// shared types and constants for the keyed length deframer
// ----------------------------------------------------------------------------
package xkld_pkg;

    localparam int KEY_BYTES = 16;

    localparam int KEY_IDX_W = 4;
    localparam int KEY_LEN_W = 5;
    localparam int KEY_VEC_W = 8 * KEY_BYTES;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_BODY   = 3'd1,
        PH_DROP   = 3'd2
    } phase_t;

    typedef logic [2:0] kind_t;

    localparam kind_t K_PAYLOAD = 3'd0;
    localparam kind_t K_CODE    = 3'd1;
    localparam kind_t K_SHORT   = 3'd2;
    localparam kind_t K_TRUNC   = 3'd3;
    localparam kind_t K_SMALL   = 3'd4;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_KEY_LENGTH = 2'd0;
    localparam cfg_index_t CFG_KEY_LOW    = 2'd1;
    localparam cfg_index_t CFG_KEY_HIGH   = 2'd2;

endpackage

>>> hdl/xkld_raw_if.sv
// ----------------------------------------------------------------------------
// xkld_raw_if
// raw buffer byte channel: one byte and an end-of-buffer flag per beat
// ----------------------------------------------------------------------------
interface xkld_raw_if;

    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       buffer_end;

    modport source (output valid, output raw_byte, output buffer_end, input ready);
    modport sink   (input valid, input raw_byte, input buffer_end, output ready);

endinterface

>>> hdl/xkld_result_if.sv
// ----------------------------------------------------------------------------
// xkld_result_if
// result channel: payload byte, packet code or error per beat
// ----------------------------------------------------------------------------
interface xkld_result_if;

    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] value;
    logic        last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);

endinterface

>>> hdl/xor_keyed_length_deframer_unit.sv
// ----------------------------------------------------------------------------
// xor_keyed_length_deframer_unit
// length-prefixed frame deframer with repeating-key xor descrambling
// ----------------------------------------------------------------------------
// Takes one raw byte per beat and returns at most one result per byte: the
// 32-bit packet code after the fourth body byte, then one payload byte per
// body byte, or an error (short prefix, truncated, length too small) with
// last set. The frame state and key index update in a single pass and the
// result lands in one output register, so a byte is accepted every cycle
// unless that register holds a result the sink has not taken. Results appear
// the cycle after the byte that causes them. The key registers may only be
// written while no byte is in flight.
module xor_keyed_length_deframer_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  xkld_pkg::cfg_index_t  cfg_index,
    input  logic [63:0]           cfg_data,
    xkld_raw_if.sink              raw,
    xkld_result_if.source         result
);
    import xkld_pkg::*;

    logic [KEY_LEN_W-1:0] key_len_reg;
    logic [63:0]          key_low_reg;
    logic [63:0]          key_high_reg;

    phase_t               phase_reg, phase_next;
    logic [31:0]          pos_reg, pos_next;
    logic [31:0]          len_reg, len_next;
    logic [23:0]          acc_reg, acc_next;
    logic [KEY_IDX_W-1:0] kidx_reg, kidx_next;

    logic                 res_valid_reg;
    kind_t                res_kind_reg;
    logic [31:0]          res_value_reg;
    logic                 res_last_reg;

    logic                 emit;
    kind_t                emit_kind;
    logic [31:0]          emit_value;
    logic                 emit_last;

    logic                 accept;
    logic [KEY_VEC_W-1:0] key_vec;
    logic [KEY_LEN_W-1:0] used_len;
    logic [KEY_LEN_W-1:0] kidx_inc;
    logic [7:0]           decoded;
    logic [31:0]          len_gathered;
    logic [31:0]          final_pos;

    assign raw.ready = !res_valid_reg || result.ready;
    assign accept    = raw.valid && raw.ready;

    assign result.valid = res_valid_reg;
    assign result.kind  = res_kind_reg;
    assign result.value = res_value_reg;
    assign result.last  = res_last_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg  <= '0;
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_LENGTH: key_len_reg  <= cfg_data[KEY_LEN_W-1:0];
                CFG_KEY_LOW:    key_low_reg  <= cfg_data;
                CFG_KEY_HIGH:   key_high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign key_vec  = {key_high_reg, key_low_reg};
    assign used_len = (key_len_reg > KEY_LEN_W'(KEY_BYTES)) ? KEY_LEN_W'(KEY_BYTES)
                                                            : key_len_reg;
    assign kidx_inc = {1'b0, kidx_reg} + KEY_LEN_W'(1);
    assign decoded  = (used_len != '0) ? (raw.raw_byte ^ key_vec[{kidx_reg, 3'b000} +: 8])
                                       : raw.raw_byte;

    assign len_gathered = len_reg | ({24'b0, raw.raw_byte} << {pos_reg[1:0], 3'b000});
    assign final_pos    = len_reg - 32'd1;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        kidx_next  = kidx_reg;
        emit       = 1'b0;
        emit_kind  = K_PAYLOAD;
        emit_value = '0;
        emit_last  = 1'b0;

        unique case (phase_reg)
            PH_PREFIX:
            begin
                len_next = len_gathered;
                if (pos_reg[1:0] != 2'd3)
                begin
                    pos_next = {30'b0, pos_reg[1:0]} + 32'd1;
                    if (raw.buffer_end)
                    begin
                        emit      = 1'b1;
                        emit_kind = K_SHORT;
                        emit_last = 1'b1;
                    end
                end
                else if (len_gathered < 32'd8)
                begin
                    emit      = 1'b1;
                    emit_kind = K_SMALL;
                    emit_last = 1'b1;
                end
                else if (raw.buffer_end)
                begin
                    emit      = 1'b1;
                    emit_kind = K_TRUNC;
                    emit_last = 1'b1;
                end
                else
                begin
                    phase_next = PH_BODY;
                    pos_next   = 32'd4;
                    acc_next   = '0;
                    kidx_next  = '0;
                end
                // any error closes the frame
                if (emit)
                begin
                    phase_next = raw.buffer_end ? PH_PREFIX : PH_DROP;
                    pos_next   = '0;
                    len_next   = '0;
                    acc_next   = '0;
                    kidx_next  = '0;
                end
            end
            PH_BODY:
            begin
                if (raw.buffer_end && (pos_reg < final_pos))
                begin
                    emit       = 1'b1;
                    emit_kind  = K_TRUNC;
                    emit_last  = 1'b1;
                    phase_next = PH_PREFIX;
                    pos_next   = '0;
                    len_next   = '0;
                    acc_next   = '0;
                    kidx_next  = '0;
                end
                else
                begin
                    if (used_len != '0)
                        kidx_next = (kidx_inc >= used_len) ? '0 : kidx_inc[KEY_IDX_W-1:0];
                    if (pos_reg < 32'd7)
                    begin
                        // positions 4..6 fill code bytes 0..2
                        acc_next = acc_reg | ({16'b0, decoded} << {pos_reg[1:0], 3'b000});
                    end
                    else
                    begin
                        emit       = 1'b1;
                        emit_kind  = (pos_reg == 32'd7) ? K_CODE : K_PAYLOAD;
                        emit_value = (pos_reg == 32'd7) ? {decoded, acc_reg}
                                                        : {24'b0, decoded};
                        emit_last  = (pos_reg == final_pos);
                    end
                    if (pos_reg >= final_pos)
                    begin
                        phase_next = raw.buffer_end ? PH_PREFIX : PH_DROP;
                        pos_next   = '0;
                        len_next   = '0;
                        acc_next   = '0;
                        kidx_next  = '0;
                    end
                    else
                        pos_next = pos_reg + 32'd1;
                end
            end
            default:
            begin
                if (raw.buffer_end)
                begin
                    phase_next = PH_PREFIX;
                    pos_next   = '0;
                    len_next   = '0;
                    acc_next   = '0;
                    kidx_next  = '0;
                end
                else
                    phase_next = PH_DROP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            pos_reg   <= '0;
            len_reg   <= '0;
            acc_reg   <= '0;
            kidx_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            kidx_reg  <= kidx_next;
        end
    end

    // result register, refilled in the same cycle the sink drains it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= emit;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            res_kind_reg  <= emit_kind;
            res_value_reg <= emit_value;
            res_last_reg  <= emit_last;
        end
    end

    a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (len_reg >= 32'd8))
        else $error("body phase with stated length below 8");

    a_body_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (pos_reg >= 32'd4 && pos_reg < len_reg))
        else $error("body position outside frame");

    a_prefix_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_BODY) |-> (pos_reg < 32'd4))
        else $error("prefix position out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(res_valid_reg && !result.ready))
        else $error("byte taken while result register stalled");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_kind_reg == K_SHORT || res_kind_reg == K_TRUNC
                           || res_kind_reg == K_SMALL))
        |-> (res_last_reg && res_value_reg == 32'd0))
        else $error("error result without last or with nonzero value");

endmodule

>>> tb/xor_keyed_length_deframer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_keyed_length_deframer_unit_tb
// self-checking bench for the keyed length deframer: raw buffers go in byte by
// byte, a frame tracker predicts codes, payload bytes and errors, and every
// result beat is compared against the oldest prediction
// ----------------------------------------------------------------------------
module xor_keyed_length_deframer_unit_tb;

    import xkld_pkg::*;

    localparam int unsigned SENDER_IDLE_PCT  = 17;
    localparam int unsigned SINK_STALL_PCT   = 17;
    localparam int unsigned SINK_HOLD_CYCLES = 120;
    localparam int unsigned DRAIN_CYCLES     = 4;
    localparam int unsigned WATCHDOG_LIMIT   = 2000;
    localparam int unsigned PHASE_BEATS      = 75;
    localparam int unsigned RANDOM_PHASES    = 8;
    localparam int unsigned MISMATCH_REPORTS = 10;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic        last;
    } frame_result_t;

    // tracks the frame state and predicts what each raw byte produces
    class deframe_tracker;
        phase_t        ph;
        logic [31:0]   pos;
        logic [31:0]   stated_len;
        logic [23:0]   code_acc;
        logic [3:0]    key_idx;
        logic [4:0]    key_len;
        logic [127:0]  key_bytes;
        frame_result_t pending_results[$];
        int unsigned   mismatches;

        function new();
            ph         = PH_PREFIX;
            key_len    = '0;
            key_bytes  = '0;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            pos        = '0;
            stated_len = '0;
            code_acc   = '0;
            key_idx    = '0;
        endfunction

        function void close_frame(logic buf_done);
            restart();
            ph = buf_done ? PH_PREFIX : PH_DROP;
        endfunction

        function void queue_result(kind_t k, logic [31:0] v, logic l);
            frame_result_t r;
            r.kind  = k;
            r.value = v;
            r.last  = l;
            pending_results.push_back(r);
        endfunction

        function void set_key(cfg_index_t idx, logic [63:0] data);
            case (idx)
                CFG_KEY_LENGTH: key_len = data[4:0];
                CFG_KEY_LOW:    key_bytes[63:0] = data;
                CFG_KEY_HIGH:   key_bytes[127:64] = data;
                default: ;
            endcase
        endfunction

        function void take_raw_byte(logic [7:0] b, logic buf_end);
            logic [1:0]  p;
            logic [31:0] last_pos;
            logic [4:0]  used;
            logic [7:0]  d;
            case (ph)
                PH_PREFIX:
                begin
                    p = pos[1:0];
                    stated_len = stated_len | ({24'd0, b} << (8 * p));
                    if (p < 2'd3) begin
                        if (buf_end) begin
                            close_frame(1'b1);
                            queue_result(K_SHORT, 32'd0, 1'b1);
                        end
                        else begin
                            pos = {30'd0, p} + 32'd1;
                        end
                    end
                    else if (stated_len < 32'd8) begin
                        close_frame(buf_end);
                        queue_result(K_SMALL, 32'd0, 1'b1);
                    end
                    else if (buf_end) begin
                        close_frame(1'b1);
                        queue_result(K_TRUNC, 32'd0, 1'b1);
                    end
                    else begin
                        ph       = PH_BODY;
                        pos      = 32'd4;
                        code_acc = '0;
                        key_idx  = '0;
                    end
                end
                PH_BODY:
                begin
                    last_pos = stated_len - 32'd1;
                    used     = (key_len > 5'd16) ? 5'd16 : key_len;
                    d        = b;
                    if (buf_end && pos < last_pos) begin
                        close_frame(1'b1);
                        queue_result(K_TRUNC, 32'd0, 1'b1);
                    end
                    else begin
                        if (used != 5'd0) begin
                            d = d ^ key_bytes[8 * key_idx +: 8];
                            // index wraps once its successor reaches the length in use
                            key_idx = (({1'b0, key_idx} + 5'd1) >= used) ? 4'd0 : key_idx + 4'd1;
                        end
                        if (pos < 32'd7)
                            code_acc = code_acc | ({16'd0, d} << (8 * (pos - 32'd4)));
                        else if (pos == 32'd7)
                            queue_result(K_CODE, {d, code_acc}, pos == last_pos);
                        else
                            queue_result(K_PAYLOAD, {24'd0, d}, pos == last_pos);
                        if (pos >= last_pos)
                            close_frame(buf_end);
                        else
                            pos = pos + 32'd1;
                    end
                end
                default:
                begin
                    // bytes past the frame are dropped until the buffer ends
                    close_frame(buf_end);
                end
            endcase
        endfunction

        function void check_result(kind_t k, logic [31:0] v, logic l);
            frame_result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MISMATCH_REPORTS)
                    $display("unexpected result beat: kind %0d value %08h last %0b", k, v, l);
                return;
            end
            want = pending_results.pop_front();
            if (want.kind !== k || want.value !== v || want.last !== l) begin
                mismatches++;
                if (mismatches <= MISMATCH_REPORTS)
                    $display("result mismatch: expected kind %0d value %08h last %0b, got kind %0d value %08h last %0b",
                             want.kind, want.value, want.last, k, v, l);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    cfg_index_t  cfg_index;
    logic [63:0] cfg_data;

    xkld_raw_if    raw_ch ();
    xkld_result_if res_ch ();

    xor_keyed_length_deframer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .raw       (raw_ch),
        .result    (res_ch)
    );

    deframe_tracker tracker;
    logic [7:0]     buf_bytes[$];
    int unsigned    beats_sent = 0;
    int unsigned    quiet_cycles = 0;
    bit             calm = 1'b0;
    bit             sink_hold_request = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog: too long without any beat on either channel
    always @(posedge clk)
    begin
        if ((raw_ch.valid === 1'b1 && raw_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("xor_keyed_length_deframer_unit verification failed");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            tracker.check_result(res_ch.kind, res_ch.value, res_ch.last);
    end

    // result sink: random stalls, plus one long hold-off on request
    initial
    begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (sink_hold_request) begin
                res_ch.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                sink_hold_request = 1'b0;
            end
            res_ch.ready <= calm || ($urandom_range(99) >= SINK_STALL_PCT);
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic e);
        while (!calm && $urandom_range(99) < SENDER_IDLE_PCT) begin
            raw_ch.valid <= 1'b0;
            @(posedge clk);
        end
        raw_ch.valid      <= 1'b1;
        raw_ch.raw_byte   <= b;
        raw_ch.buffer_end <= e;
        @(posedge clk);
        while (raw_ch.ready !== 1'b1) @(posedge clk);
        tracker.take_raw_byte(b, e);
        beats_sent++;
    endtask

    // buffer_end goes on the final byte of the buffer only
    task automatic send_range(input int first, input int last_idx);
        for (int i = first; i <= last_idx; i++)
            send_beat(buf_bytes[i], i == buf_bytes.size() - 1);
    endtask

    task automatic send_all();
        send_range(0, buf_bytes.size() - 1);
    endtask

    task automatic drain();
        raw_ch.valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_keys(input logic [63:0] len_word, input logic [63:0] lo,
                              input logic [63:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_KEY_LENGTH;
        cfg_data  <= len_word;
        tracker.set_key(CFG_KEY_LENGTH, len_word);
        @(posedge clk);
        cfg_index <= CFG_KEY_LOW;
        cfg_data  <= lo;
        tracker.set_key(CFG_KEY_LOW, lo);
        @(posedge clk);
        cfg_index <= CFG_KEY_HIGH;
        cfg_data  <= hi;
        tracker.set_key(CFG_KEY_HIGH, hi);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] random_key_word();
        case ($urandom_range(3))
            0:       return 64'd0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic pick_keys();
        logic [4:0]  len;
        logic [63:0] len_word;
        case ($urandom_range(4))
            0:       len = 5'd0;
            1:       len = 5'd1;
            2:       len = 5'd16;
            3:       len = 5'd31;
            default: len = 5'($urandom_range(31));
        endcase
        // upper bits of the length word are sometimes junk
        len_word = {$urandom, $urandom};
        if ($urandom_range(1) == 0)
            len_word = 64'(len);
        else
            len_word[4:0] = len;
        write_keys(len_word, random_key_word(), random_key_word());
    endtask

    function automatic void make_frame(input int unsigned len, input int unsigned tail);
        buf_bytes.delete();
        for (int unsigned i = 0; i < 4; i++)
            buf_bytes.push_back(8'(len >> (8 * i)));
        for (int unsigned i = 4; i < len; i++)
            buf_bytes.push_back(8'($urandom));
        repeat (tail) buf_bytes.push_back(8'($urandom));
    endfunction

    task automatic random_buffer();
        int unsigned pick;
        int unsigned cut;
        pick = $urandom_range(99);
        if (pick < 68) begin
            make_frame(($urandom_range(19) == 0) ? $urandom_range(8, 64) : $urandom_range(8, 20),
                       ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 3));
        end
        else if (pick < 78) begin
            // buffer cut short anywhere from the last prefix byte on
            make_frame($urandom_range(9, 24), 0);
            cut = $urandom_range(4, buf_bytes.size() - 1);
            while (buf_bytes.size() > cut) void'(buf_bytes.pop_back());
        end
        else if (pick < 84) begin
            buf_bytes.delete();
            repeat ($urandom_range(1, 3)) buf_bytes.push_back(8'($urandom));
        end
        else if (pick < 90) begin
            make_frame($urandom_range(0, 7), $urandom_range(0, 3));
        end
        else if (pick < 95) begin
            // junk prefix, mostly a huge stated length
            buf_bytes.delete();
            repeat ($urandom_range(4, 14)) buf_bytes.push_back(8'($urandom));
        end
        else begin
            send_beat(8'($urandom), $urandom_range(3) == 0);
            return;
        end
        send_all();
    endtask

    task automatic run_random_phase(input int unsigned beats);
        int unsigned start_count;
        start_count = beats_sent;
        while (beats_sent - start_count < beats) random_buffer();
    endtask

    initial
    begin
        tracker = new();
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_KEY_LENGTH;
        cfg_data          <= 64'd0;
        raw_ch.valid      <= 1'b0;
        raw_ch.raw_byte   <= 8'd0;
        raw_ch.buffer_end <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // minimum frame, code only, with all-ones body and no key
        buf_bytes = '{8'h08, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_all();
        // short prefix
        buf_bytes = '{8'h00};
        send_all();
        // zero stated length ending with the prefix
        buf_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_all();
        // stated length just below the minimum, remainder dropped
        buf_bytes = '{8'h07, 8'h00, 8'h00, 8'h00, 8'hAA};
        send_all();
        // valid length but the buffer ends with the prefix
        buf_bytes = '{8'h09, 8'h00, 8'h00, 8'h00};
        send_all();

        // key length changed in the middle of a frame
        drain();
        write_keys(64'd3, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
        make_frame(10, 1);
        send_range(0, 5);
        drain();
        write_keys(64'd2, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
        send_range(6, buf_bytes.size() - 1);

        for (int unsigned ph_i = 0; ph_i < RANDOM_PHASES; ph_i++) begin
            drain();
            case (ph_i)
                0:       write_keys(64'd16, '1, '1);
                1:       write_keys(64'd0, '1, '1);
                2:       write_keys(64'd31, random_key_word(), random_key_word());
                default: pick_keys();
            endcase
            calm = (ph_i == 3);
            if (ph_i == 5)
                sink_hold_request = 1'b1;
            run_random_phase(PHASE_BEATS);
        end
        drain();
        calm = 1'b0;

        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("xor_keyed_length_deframer_unit verification clean");
        else
            $display("xor_keyed_length_deframer_unit verification failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/xkld_pkg.sv
hdl/xkld_raw_if.sv
hdl/xkld_result_if.sv
hdl/xor_keyed_length_deframer_unit.sv
tb/xor_keyed_length_deframer_unit_tb.sv
